FILE: hw/rtl/errpr_pkg.sv
// ----------------------------------------------------------------------------
// errpr_pkg
// Shared types and constants of the EPI row reverse / phase rotate block:
// register map, coefficient format and rounding constants.
// ----------------------------------------------------------------------------
package errpr_pkg;

   // Coefficient format: signed Q2.14
   localparam int COEF_W     = 16;
   localparam int FRAC_BITS  = 14;
   localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);

   // Register port geometry
   localparam int ROW_LEN_W  = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef logic signed [COEF_W-1:0]    coef_type;
   typedef logic [ROW_LEN_W-1:0]        row_len_type;
   typedef logic [CSR_IDX_W-1:0]        csr_index_type;
   typedef logic [CSR_DATA_W-1:0]       csr_data_type;

   // Register indexes
   localparam csr_index_type CSR_ROW_LENGTH  = 3'd0;
   localparam csr_index_type CSR_REV_ODD     = 3'd1;
   localparam csr_index_type CSR_REV_EVEN    = 3'd2;
   localparam csr_index_type CSR_COS_TERM    = 3'd3;
   localparam csr_index_type CSR_SIN_TERM    = 3'd4;

   // Register reset values
   localparam row_len_type ROW_LEN_RESET = 7'd64;
   localparam coef_type    COS_RESET     = 16'sd16384;
   localparam coef_type    SIN_RESET     = 16'sd0;

endpackage

FILE: hw/rtl/errpr_if.sv
// ----------------------------------------------------------------------------
// errpr_if
// Valid/ready channel interfaces of the EPI row reverse / phase rotate
// block: pixel input, corrected pixel output and register writes.
// ----------------------------------------------------------------------------

// Pixel input channel
interface errpr_req_if #(parameter int SAMPLE_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] pix_re;
   logic signed [SAMPLE_BITS-1:0] pix_im;
   logic                          image_start;

   modport source (output valid, output pix_re, output pix_im, output image_start,
                   input ready);
   modport sink   (input valid, input pix_re, input pix_im, input image_start,
                   output ready);
endinterface

// Corrected pixel output channel
interface errpr_rsp_if #(parameter int SAMPLE_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] out_re;
   logic signed [SAMPLE_BITS-1:0] out_im;
   logic                          row_end;
   logic                          burst_last;

   modport source (output valid, output out_re, output out_im, output row_end,
                   output burst_last, input ready);
   modport sink   (input valid, input out_re, input out_im, input row_end,
                   input burst_last, output ready);
endinterface

// Register write channel
interface errpr_csr_if;
   logic                    valid;
   logic                    ready;
   errpr_pkg::csr_index_type index;
   errpr_pkg::csr_data_type  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/epi_row_reverse_phase_rotate_core.sv
// ----------------------------------------------------------------------------
// epi_row_reverse_phase_rotate_core
// Row reversal and opposite-sign phase rotation for EPI Nyquist ghost
// correction. Reversing rows are kept in a line buffer and replayed
// backwards on their last pixel; all pixels are rotated by +/- phase.
// ----------------------------------------------------------------------------
//  Channel   Dir  Payload                                  Transfer when
//  req_bus   in   pix_re, pix_im, image_start              valid & ready
//  rsp_bus   out  out_re, out_im, row_end, burst_last      valid & ready
//  csr_bus   in   index, data                              valid (ready tied high)
//
//  Pass-through pixels: one per cycle when not stalled, via stages 0, 1, 2.
//  Stored pixels of a reversing row: one per cycle when not stalled, no output.
//  Last pixel of a reversing row: the row is read back from the line buffer
//  (one read port), during which req_bus is held off.
//  Synchronous active-high reset clears counters, state and config.
//  A stalled rsp_bus freezes the whole rotate pipeline and the buffer reads.
// ----------------------------------------------------------------------------
module epi_row_reverse_phase_rotate_core #(
   parameter int MAX_ROW     = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   errpr_req_if.sink   req_bus,
   errpr_rsp_if.source rsp_bus,
   errpr_csr_if.sink   csr_bus
);
   import errpr_pkg::*;

   localparam int AW = $clog2(MAX_ROW);
   localparam int SB = SAMPLE_BITS;
   localparam int PW = SB + COEF_W;       // product width
   localparam int SW = PW + 1;            // sum width
   localparam int QW = SW - FRAC_BITS;    // rounded width

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_BURST = 1'b1;

   // Round half up, drop fraction, saturate to the sample width
   function automatic logic signed [SB-1:0] round_sat(input logic signed [SW-1:0] s);
      logic signed [SW-1:0] b;
      logic        [QW-1:0] q;
      logic                 fits;
      b = s + SW'(ROUND_HALF);
      q = b[SW-1:FRAC_BITS];
      fits = (q[QW-1:SB-1] == '0) || (q[QW-1:SB-1] == '1);
      if (fits) begin
         round_sat = q[SB-1:0];
      end else if (q[QW-1]) begin
         round_sat = {1'b1, {(SB-1){1'b0}}};
      end else begin
         round_sat = {1'b0, {(SB-1){1'b1}}};
      end
   endfunction

   // ---------------------------------------------------------------- config
   row_len_type row_length_ff;
   logic        rev_odd_ff;
   logic        rev_even_ff;
   coef_type    cos_ff;
   coef_type    sin_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= ROW_LEN_RESET;
         rev_odd_ff    <= 1'b0;
         rev_even_ff   <= 1'b0;
         cos_ff        <= COS_RESET;
         sin_ff        <= SIN_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_ROW_LENGTH: row_length_ff <= csr_bus.data[ROW_LEN_W-1:0];
            CSR_REV_ODD:    rev_odd_ff    <= csr_bus.data[0];
            CSR_REV_EVEN:   rev_even_ff   <= csr_bus.data[0];
            CSR_COS_TERM:   cos_ff        <= csr_bus.data;
            CSR_SIN_TERM:   sin_ff        <= csr_bus.data;
            default: ;
         endcase
      end
   end

   // Effective row length, clamped to [2, MAX_ROW]
   row_len_type len;
   row_len_type len_m1;

   always_comb begin
      if (row_length_ff < 7'd2) begin
         len = 7'd2;
      end else if (row_length_ff > ROW_LEN_W'(MAX_ROW)) begin
         len = ROW_LEN_W'(MAX_ROW);
      end else begin
         len = row_length_ff;
      end
      len_m1 = len - 7'd1;
   end

   // ---------------------------------------------------------------- control
   logic          state_ff,     state_in;
   row_len_type   col_ff,       col_in;
   logic          odd_ff,       odd_in;
   logic [AW-1:0] rd_addr_ff,   rd_addr_in;
   logic          burst_odd_ff, burst_odd_in;
   logic          s0_valid_ff,  s0_valid_in;
   logic          s1_valid_ff;
   logic          rsp_valid_ff;

   logic          advance;
   logic          accept;
   row_len_type   col_cur;
   logic          odd_cur;
   logic          rev_cur;
   logic          last_cur;
   logic [AW-1:0] wr_addr;
   logic          mem_wr;
   logic          mem_rd;
   logic          rd_final;

   // Whole pipeline moves unless the output register is stalled
   assign advance       = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE) && advance;
   assign accept        = req_bus.valid && req_bus.ready;

   // Position of the incoming pixel; image start restarts at an even row
   assign col_cur  = req_bus.image_start ? '0 : col_ff;
   assign odd_cur  = req_bus.image_start ? 1'b0 : odd_ff;
   assign rev_cur  = odd_cur ? rev_odd_ff : rev_even_ff;
   assign last_cur = (col_cur >= len_m1);
   assign wr_addr  = last_cur ? len_m1[AW-1:0] : col_cur[AW-1:0];

   assign mem_wr   = accept && rev_cur;
   assign mem_rd   = (state_ff == ST_BURST) && advance;
   assign rd_final = (rd_addr_ff == '0);

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      odd_in       = odd_ff;
      rd_addr_in   = rd_addr_ff;
      burst_odd_in = burst_odd_ff;
      s0_valid_in  = s0_valid_ff;

      if (accept) begin
         if (last_cur) begin
            col_in = '0;
            odd_in = !odd_cur;
         end else begin
            col_in = col_cur + 7'd1;
            odd_in = odd_cur;
         end
         // Last pixel of a reversing row: replay from the end backwards
         if (rev_cur && last_cur) begin
            state_in     = ST_BURST;
            rd_addr_in   = len_m1[AW-1:0];
            burst_odd_in = odd_cur;
         end
      end

      if (mem_rd) begin
         if (rd_final) begin
            state_in = ST_IDLE;
         end else begin
            rd_addr_in = rd_addr_ff - AW'(1);
         end
      end

      if (advance) begin
         s0_valid_in = (accept && !rev_cur) || mem_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         odd_ff       <= 1'b0;
         rd_addr_ff   <= '0;
         burst_odd_ff <= 1'b0;
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         odd_ff       <= odd_in;
         rd_addr_ff   <= rd_addr_in;
         burst_odd_ff <= burst_odd_in;
         s0_valid_ff  <= s0_valid_in;
         if (advance) begin
            s1_valid_ff  <= s0_valid_ff;
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   // ---------------------------------------------------------------- line buffer
   logic [2*SB-1:0] line_mem [MAX_ROW];
   logic [2*SB-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         line_mem[wr_addr] <= {req_bus.pix_im, req_bus.pix_re};
      end
      if (mem_rd) begin
         rd_data_ff <= line_mem[rd_addr_ff];
      end
   end

   // ---------------------------------------------------------------- stage 0: operands
   logic                 s0_mem_ff;
   logic                 s0_odd_ff;
   logic                 s0_rend_ff;
   logic                 s0_blast_ff;
   logic signed [SB-1:0] pix_re_ff;
   logic signed [SB-1:0] pix_im_ff;
   logic signed [SB-1:0] s0_re;
   logic signed [SB-1:0] s0_im;

   always_ff @(posedge clock) begin
      if (advance) begin
         if (mem_rd) begin
            s0_mem_ff   <= 1'b1;
            s0_odd_ff   <= burst_odd_ff;
            s0_rend_ff  <= rd_final;
            s0_blast_ff <= rd_final;
         end else begin
            s0_mem_ff   <= 1'b0;
            s0_odd_ff   <= odd_cur;
            s0_rend_ff  <= last_cur;
            s0_blast_ff <= 1'b1;
         end
         pix_re_ff <= req_bus.pix_re;
         pix_im_ff <= req_bus.pix_im;
      end
   end

   assign s0_re = s0_mem_ff ? rd_data_ff[SB-1:0]    : pix_re_ff;
   assign s0_im = s0_mem_ff ? rd_data_ff[2*SB-1:SB] : pix_im_ff;

   // ---------------------------------------------------------------- stage 1: products
   logic signed [PW-1:0] p_cr_ff;
   logic signed [PW-1:0] p_si_ff;
   logic signed [PW-1:0] p_ci_ff;
   logic signed [PW-1:0] p_sr_ff;
   logic                 s1_odd_ff;
   logic                 s1_rend_ff;
   logic                 s1_blast_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         p_cr_ff     <= PW'(cos_ff) * PW'(s0_re);
         p_si_ff     <= PW'(sin_ff) * PW'(s0_im);
         p_ci_ff     <= PW'(cos_ff) * PW'(s0_im);
         p_sr_ff     <= PW'(sin_ff) * PW'(s0_re);
         s1_odd_ff   <= s0_odd_ff;
         s1_rend_ff  <= s0_rend_ff;
         s1_blast_ff <= s0_blast_ff;
      end
   end

   // ---------------------------------------------------------------- stage 2: sum, round
   // odd rows rotate by +phase, even rows by -phase
   logic signed [SW-1:0] sum_re;
   logic signed [SW-1:0] sum_im;

   always_comb begin
      if (s1_odd_ff) begin
         sum_re = SW'(p_cr_ff) - SW'(p_si_ff);
         sum_im = SW'(p_ci_ff) + SW'(p_sr_ff);
      end else begin
         sum_re = SW'(p_cr_ff) + SW'(p_si_ff);
         sum_im = SW'(p_ci_ff) - SW'(p_sr_ff);
      end
   end

   logic signed [SB-1:0] out_re_ff;
   logic signed [SB-1:0] out_im_ff;
   logic                 row_end_ff;
   logic                 burst_last_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         out_re_ff     <= round_sat(sum_re);
         out_im_ff     <= round_sat(sum_im);
         row_end_ff    <= s1_rend_ff;
         burst_last_ff <= s1_blast_ff;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.out_re     = out_re_ff;
   assign rsp_bus.out_im     = out_im_ff;
   assign rsp_bus.row_end    = row_end_ff;
   assign rsp_bus.burst_last = burst_last_ff;

endmodule
